FILE: hdl/assert_macros.svh
// assertion macros for the rtl file that checks itself, the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ESD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esd assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ESD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esd assertion failed");

`endif

FILE: hdl/esd_pkg.sv
// types, constants and helper functions of the escape sequence decoder
package esd_pkg;

	localparam int unsigned LINE_COUNT_BITS = 16;
	localparam int unsigned LINE_NUM_W = 16;
	localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
	localparam logic [LINE_COUNT_BITS-1:0] LINE_INIT = LINE_COUNT_BITS'(1);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BSL = 8'h5C;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_SKIP_LF = 2'd2,
		MODE_SKIP_CR = 2'd3
	} esd_mode_t;

	// one classified input byte: up to two results
	typedef struct packed {
		logic two;
		logic [7:0] byte0;
		logic end0;
		logic [LINE_NUM_W-1:0] line0;
		logic [7:0] byte1;
		logic end1;
		logic [LINE_NUM_W-1:0] line1;
	} esd_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic [QCNT_W-1:0] count;
	} esd_qstat_t;

	typedef struct packed {
		logic hit;
		logic [7:0] code;
	} esd_esc_t;

	// known escape letters and the bytes they stand for
	function automatic esd_esc_t esc_map(input logic [7:0] c);
		esd_esc_t r;
		r.hit = 1'b1;
		r.code = c;
		case (c)
			8'h5C, 8'h22, 8'h3F, 8'h27: r.code = c;
			8'h61: r.code = 8'h07; // a
			8'h62: r.code = 8'h08; // b
			8'h66: r.code = 8'h0C; // f
			8'h6E: r.code = 8'h0A; // n
			8'h72: r.code = 8'h0D; // r
			8'h74: r.code = 8'h09; // t
			8'h76: r.code = 8'h0B; // v
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// low bits of the line count as shown on the output
	function automatic logic [LINE_NUM_W-1:0] line_field(input logic [LINE_COUNT_BITS-1:0] c);
		logic [LINE_COUNT_BITS+LINE_NUM_W-1:0] wide;
		wide = (LINE_COUNT_BITS + LINE_NUM_W)'(c);
		return wide[LINE_NUM_W-1:0];
	endfunction

endpackage

FILE: hdl/esd_front.sv
// front end: decode mode, line counter and byte classification
module esd_front (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] in_byte,
	output logic push,
	output esd_pkg::esd_entry_t entry
);

	esd_pkg::esd_mode_t mode_q;
	esd_pkg::esd_mode_t mode_d;
	logic [esd_pkg::LINE_COUNT_BITS-1:0] line_q;
	logic [esd_pkg::LINE_COUNT_BITS-1:0] line_inc;
	logic bump;
	logic is_brk;
	logic skip_hit;
	esd_pkg::esd_esc_t esc;

	assign is_brk = (in_byte == esd_pkg::CH_CR) || (in_byte == esd_pkg::CH_LF);
	assign skip_hit = ((mode_q == esd_pkg::MODE_SKIP_LF) && (in_byte == esd_pkg::CH_LF)) ||
		((mode_q == esd_pkg::MODE_SKIP_CR) && (in_byte == esd_pkg::CH_CR));
	assign esc = esd_pkg::esc_map(in_byte);
	assign line_inc = (line_q == esd_pkg::LINE_MAX) ? line_q :
		esd_pkg::LINE_COUNT_BITS'(line_q + 1'b1);

	// next state
	always_comb begin
		mode_d = esd_pkg::MODE_NORMAL;
		bump = 1'b0;
		case (mode_q)
			esd_pkg::MODE_ESCAPE: begin
				if (is_brk) begin
					bump = 1'b1;
					mode_d = (in_byte == esd_pkg::CH_CR) ? esd_pkg::MODE_SKIP_LF :
						esd_pkg::MODE_SKIP_CR;
				end else if (in_byte == esd_pkg::CH_NUL) begin
					bump = 1'b1;
				end
			end
			default: begin
				if (skip_hit) begin
					mode_d = esd_pkg::MODE_NORMAL;
				end else if (in_byte == esd_pkg::CH_BSL) begin
					mode_d = esd_pkg::MODE_ESCAPE;
				end else if (in_byte == esd_pkg::CH_CR) begin
					bump = 1'b1;
					mode_d = esd_pkg::MODE_SKIP_LF;
				end else if (in_byte == esd_pkg::CH_LF) begin
					bump = 1'b1;
					mode_d = esd_pkg::MODE_SKIP_CR;
				end else if (in_byte == esd_pkg::CH_NUL) begin
					bump = 1'b1;
				end
			end
		endcase
	end

	// results of this byte
	always_comb begin
		push = 1'b0;
		entry = '0;
		entry.line0 = esd_pkg::line_field(line_q);
		entry.line1 = esd_pkg::line_field(line_q);
		case (mode_q)
			esd_pkg::MODE_ESCAPE: begin
				if (is_brk) begin
					push = 1'b0;
				end else if (in_byte == esd_pkg::CH_NUL) begin
					push = fire;
					entry.two = 1'b1;
					entry.byte0 = esd_pkg::CH_BSL;
					entry.byte1 = esd_pkg::CH_NUL;
					entry.end1 = 1'b1;
					entry.line1 = esd_pkg::line_field(line_inc);
				end else if (esc.hit) begin
					push = fire;
					entry.byte0 = esc.code;
				end else begin
					push = fire;
					entry.two = 1'b1;
					entry.byte0 = esd_pkg::CH_BSL;
					entry.byte1 = in_byte;
				end
			end
			default: begin
				if (skip_hit || (in_byte == esd_pkg::CH_BSL)) begin
					push = 1'b0;
				end else if (is_brk || (in_byte == esd_pkg::CH_NUL)) begin
					push = fire;
					entry.byte0 = esd_pkg::CH_NUL;
					entry.end0 = 1'b1;
					entry.line0 = esd_pkg::line_field(line_inc);
				end else begin
					push = fire;
					entry.byte0 = in_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esd_pkg::MODE_NORMAL;
			line_q <= esd_pkg::LINE_INIT;
		end else if (fire) begin
			mode_q <= mode_d;
			if (bump) begin
				line_q <= line_inc;
			end
		end
	end

endmodule

FILE: hdl/esd_queue.sv
// short queue of classified bytes between front and back
module esd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input esd_pkg::esd_entry_t push_entry,
	input logic pop,
	output esd_pkg::esd_entry_t head,
	output esd_pkg::esd_qstat_t stat
);

	esd_pkg::esd_entry_t mem_q [esd_pkg::QDEPTH];
	logic [esd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [esd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [esd_pkg::QCNT_W-1:0] count_q;

	assign head = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == esd_pkg::QCNT_W'(esd_pkg::QDEPTH));
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= esd_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= esd_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= esd_pkg::QCNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= esd_pkg::QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

FILE: hdl/esd_back.sv
// back end: splits queue entries into results and holds the output register
module esd_back (
	input logic clk,
	input logic arst_n,
	input esd_pkg::esd_entry_t head,
	input esd_pkg::esd_qstat_t stat,
	output logic pop,
	output logic half,
	input logic out_stall,
	output logic out_valid,
	output logic [7:0] out_byte,
	output logic is_end,
	output logic [esd_pkg::LINE_NUM_W-1:0] line_number
);

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_end_q;
	logic [esd_pkg::LINE_NUM_W-1:0] out_line_q;
	logic half_q;
	logic load;
	logic take;

	assign load = !out_valid_q || !out_stall;
	assign take = load && !stat.empty;
	assign pop = take && (!head.two || half_q);
	assign half = half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (take) begin
				half_q <= head.two && !half_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= half_q ? head.byte1 : head.byte0;
			out_end_q <= half_q ? head.end1 : head.end0;
			out_line_q <= half_q ? head.line1 : head.line0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign is_end = out_end_q;
	assign line_number = out_line_q;

endmodule

FILE: hdl/escape_sequence_decoder.sv
// top level of the escape sequence decoder: front, queue and back
// path: a byte's first result goes into a queue entry, then into the output register
// throughput: one byte per cycle while the queue has room; two results take two transfers
// rate is set by the single output register; the four-entry queue absorbs output stalls
// reset: decode mode normal, line count 1, queue and output register empty
`include "assert_macros.svh"

module escape_sequence_decoder (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic is_end,
	output logic [esd_pkg::LINE_NUM_W-1:0] line_number
);

	logic fire;
	logic q_push;
	logic q_pop;
	logic back_half;
	esd_pkg::esd_entry_t push_entry;
	esd_pkg::esd_entry_t q_head;
	esd_pkg::esd_qstat_t q_stat;

	// input transfer whenever the queue has room; bytes with no result never enter it
	assign in_stall = q_stat.full;
	assign fire = in_valid && !in_stall;

	// front: tracks escape and partner-drop mode and the saturating line count
	esd_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.fire (fire),
		.in_byte (in_byte),
		.push (q_push),
		.entry (push_entry)
	);

	// queue: decouples classification from output back-pressure
	esd_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (q_push),
		.push_entry (push_entry),
		.pop (q_pop),
		.head (q_head),
		.stat (q_stat)
	);

	// back: one result per output transfer, second half of a pair on the next
	esd_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (q_head),
		.stat (q_stat),
		.pop (q_pop),
		.half (back_half),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte (out_byte),
		.is_end (is_end),
		.line_number (line_number)
	);

	// checks
	`ESD_ASSERT_NOW(a_no_push_full, q_stat.full, !q_push)
	`ESD_ASSERT_NOW(a_half_needs_entry, back_half, !q_stat.empty)
	`ESD_ASSERT_NOW(a_end_is_zero, out_valid && is_end, out_byte == esd_pkg::CH_NUL)
	`ESD_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_stat.count == esd_pkg::QCNT_W'($past(q_stat.count) + 1'b1))

endmodule

FILE: tb/tb_escape_sequence_decoder.sv
// testbench of the escape sequence decoder: directed and random byte streams against a decode model
module tb_escape_sequence_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transfer on either side before the run is given up
	localparam int unsigned STUCK_LIMIT = 4000;
	// input bytes offered in each random phase
	localparam int unsigned PHASE_BYTES = 400;
	// every byte that forms a known escape after a backslash
	localparam string ESC_LETTERS = "\\\"?'abfnrtv";

	// one decoded character as seen on the output side
	typedef struct packed {
		logic [7:0] text;
		logic last;
		logic [esd_pkg::LINE_NUM_W-1:0] line;
	} decoded_char_t;

	// tracks decode mode and line count, and holds the characters still owed by the block
	class escape_decode_tracker;
		esd_pkg::esd_mode_t mode;
		logic [esd_pkg::LINE_COUNT_BITS-1:0] lines;
		decoded_char_t pending_chars[$];
		int unsigned mismatches;

		function new();
			mode = esd_pkg::MODE_NORMAL;
			lines = esd_pkg::LINE_INIT;
			mismatches = 0;
		endfunction

		task report(input string msg);
			$display("%0t ns: %s", $time, msg);
			mismatches++;
		endtask

		function void count_line();
			if (lines != esd_pkg::LINE_MAX)
				lines++;
		endfunction

		function void emit(input logic [7:0] c, input logic last);
			pending_chars.push_back(decoded_char_t'{c, last, esd_pkg::LINE_NUM_W'(lines)});
		endfunction

		// byte that a known escape letter stands for
		function bit escape_value(input logic [7:0] c, output logic [7:0] v);
			escape_value = 1'b1;
			v = c;
			case (c)
				esd_pkg::CH_BSL, "\"", "?", "'": v = c;
				"a": v = 8'h07;
				"b": v = 8'h08;
				"f": v = 8'h0C;
				"n": v = 8'h0A;
				"r": v = 8'h0D;
				"t": v = 8'h09;
				"v": v = 8'h0B;
				default: escape_value = 1'b0;
			endcase
		endfunction

		// one accepted input byte: update the mode and queue what it decodes to
		function void note_byte(input logic [7:0] c);
			logic [7:0] v;
			if (mode == esd_pkg::MODE_ESCAPE) begin
				if (c == esd_pkg::CH_CR || c == esd_pkg::CH_LF) begin
					// line continuation: nothing out, one line counted
					count_line();
					mode = (c == esd_pkg::CH_CR) ? esd_pkg::MODE_SKIP_LF :
						esd_pkg::MODE_SKIP_CR;
				end else begin
					mode = esd_pkg::MODE_NORMAL;
					if (c == esd_pkg::CH_NUL) begin
						emit(esd_pkg::CH_BSL, 1'b0);
						count_line();
						emit(esd_pkg::CH_NUL, 1'b1);
					end else if (escape_value(c, v)) begin
						emit(v, 1'b0);
					end else begin
						emit(esd_pkg::CH_BSL, 1'b0);
						emit(c, 1'b0);
					end
				end
			end else if ((mode == esd_pkg::MODE_SKIP_LF && c == esd_pkg::CH_LF) ||
					(mode == esd_pkg::MODE_SKIP_CR && c == esd_pkg::CH_CR)) begin
				// partner of a line break pair is swallowed
				mode = esd_pkg::MODE_NORMAL;
			end else if (c == esd_pkg::CH_BSL) begin
				mode = esd_pkg::MODE_ESCAPE;
			end else if (c == esd_pkg::CH_CR || c == esd_pkg::CH_LF ||
					c == esd_pkg::CH_NUL) begin
				count_line();
				if (c == esd_pkg::CH_CR)
					mode = esd_pkg::MODE_SKIP_LF;
				else if (c == esd_pkg::CH_LF)
					mode = esd_pkg::MODE_SKIP_CR;
				else
					mode = esd_pkg::MODE_NORMAL;
				emit(esd_pkg::CH_NUL, 1'b1);
			end else begin
				mode = esd_pkg::MODE_NORMAL;
				emit(c, 1'b0);
			end
		endfunction

		// one accepted output character against the oldest one owed
		task check_char(input logic [7:0] text, input logic last,
				input logic [esd_pkg::LINE_NUM_W-1:0] line);
			decoded_char_t want;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected character %02h end %0b line %0d", text, last, line));
			end else begin
				want = pending_chars.pop_front();
				if (text != want.text)
					report($sformatf("out_byte %02h, wanted %02h", text, want.text));
				if (last != want.last)
					report($sformatf("is_end %0b, wanted %0b (byte %02h)", last, want.last, want.text));
				if (line != want.line)
					report($sformatf("line_number %0d, wanted %0d (byte %02h)", line, want.line,
						want.text));
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic is_end;
	logic [esd_pkg::LINE_NUM_W-1:0] line_number;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned stuck_cycles = 0;

	escape_decode_tracker tracker = new();

	escape_sequence_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.is_end(is_end),
		.line_number(line_number)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiving side: stall at random, at the rate of the current phase
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// transfers are sampled on the edge itself, so all values are the ones from before it;
	// a result never comes from the byte taken on the same edge, so the order here is free
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_char(out_byte, is_end, line_number);
			if (in_valid && !in_stall)
				tracker.note_byte(in_byte);
		end
	end

	// watchdog: a long run of cycles without any transfer means the block has hung
	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
			stuck_cycles++;
		else
			stuck_cycles = 0;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one byte, with idle cycles first at the phase rate, and hold it until transferred
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			in_byte <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// let the last transfer be noted, then wait until nothing is owed
	task automatic wait_drained();
		@(posedge clk);
		while (tracker.pending_chars.size() != 0)
			@(posedge clk);
	endtask

	// a line break in one of its forms, pairs and doubled breaks included, or a nul
	task automatic send_line_end();
		case ($urandom_range(5))
			0: send_byte(esd_pkg::CH_CR);
			1: send_byte(esd_pkg::CH_LF);
			2: begin
				send_byte(esd_pkg::CH_CR);
				send_byte(esd_pkg::CH_LF);
			end
			3: begin
				send_byte(esd_pkg::CH_LF);
				send_byte(esd_pkg::CH_CR);
			end
			4: begin
				send_byte(esd_pkg::CH_CR);
				send_byte(esd_pkg::CH_CR);
			end
			default: send_byte(esd_pkg::CH_NUL);
		endcase
	endtask

	// mostly well-formed text with random content, plus raw noise and odd escapes
	task automatic send_random_fragment();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 38) begin
			send_byte(8'($urandom_range(32, 126)));
		end else if (pick < 48) begin
			// any byte at all, so every bit of in_byte is exercised
			send_byte(8'($urandom));
		end else if (pick < 68) begin
			send_byte(esd_pkg::CH_BSL);
			send_byte(ESC_LETTERS[$urandom_range(ESC_LETTERS.len() - 1)]);
		end else if (pick < 76) begin
			// backslash before an arbitrary byte: mostly unknown escapes
			send_byte(esd_pkg::CH_BSL);
			send_byte(8'($urandom));
		end else if (pick < 88) begin
			send_line_end();
		end else begin
			// continuation, continuation with partner, or backslash before nul
			send_byte(esd_pkg::CH_BSL);
			send_line_end();
		end
	endtask

	// one random phase at the given idle and stall rates, paused once mid-way until drained
	task automatic run_phase(input int unsigned idle, input int unsigned stall,
			input int unsigned nbytes);
		int unsigned start;
		int unsigned pause_at;
		bit paused;
		send_idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent;
		pause_at = $urandom_range(nbytes / 4, nbytes * 3 / 4);
		paused = 1'b0;
		while (bytes_sent - start < nbytes) begin
			send_random_fragment();
			if (!paused && bytes_sent - start >= pause_at) begin
				in_valid <= 1'b0;
				wait_drained();
				paused = 1'b1;
			end
		end
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back with no stalls
		send_byte("A");
		send_byte(8'hFF);		// top of the byte range
		send_byte(esd_pkg::CH_BSL);	// escaped backslash
		send_byte(esd_pkg::CH_BSL);
		send_byte(esd_pkg::CH_BSL);	// escaped double quote
		send_byte("\"");
		send_byte(esd_pkg::CH_BSL);	// bell
		send_byte("a");
		send_byte(esd_pkg::CH_BSL);	// vertical tab
		send_byte("v");
		send_byte(esd_pkg::CH_BSL);	// unknown escape: both bytes pass through
		send_byte("z");
		send_byte(esd_pkg::CH_BSL);	// continuation by cr, its lf partner swallowed
		send_byte(esd_pkg::CH_CR);
		send_byte(esd_pkg::CH_LF);
		send_byte(esd_pkg::CH_BSL);	// continuation by lf, its cr partner swallowed
		send_byte(esd_pkg::CH_LF);
		send_byte(esd_pkg::CH_CR);
		send_byte(esd_pkg::CH_CR);	// end by cr, lf partner swallowed
		send_byte(esd_pkg::CH_LF);
		send_byte(8'h80);
		send_byte(esd_pkg::CH_BSL);	// backslash before nul: backslash then end marker
		send_byte(esd_pkg::CH_NUL);
		send_byte(esd_pkg::CH_NUL);	// plain nul after escapes still counts a line
		send_byte(esd_pkg::CH_LF);	// two lf in a row: the second is not a partner
		send_byte(esd_pkg::CH_LF);
		in_valid <= 1'b0;
		wait_drained();

		// random phases: free running, sender idling, receiver stalling, both
		run_phase(0, 0, PHASE_BYTES);
		run_phase(59, 0, PHASE_BYTES);
		run_phase(0, 59, PHASE_BYTES);
		run_phase(13, 13, PHASE_BYTES);

		// a quiet spell to catch any stray character
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/esd_pkg.sv
hdl/esd_front.sv
hdl/esd_queue.sv
hdl/esd_back.sv
hdl/escape_sequence_decoder.sv
tb/tb_escape_sequence_decoder.sv
